### sv/bnf_pkg.sv
// Shared types, field widths and codes for the box neighbour filter.
package bnf_pkg;

    // Fixed field widths
    localparam int FIELD_W     = 32;
    localparam int SLOT_W      = 4;
    localparam int PERIOD_W    = 5;
    localparam int SEQ_W       = 16;
    localparam int RANK_OUT_W  = 16;
    localparam int DIST_W      = 31;
    localparam int LCOUNT_W    = 5;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    // Request operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAND = 1'b1;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Register indexes (byte address 4 * index)
    localparam logic [1:0] REG_GAP_LIMIT    = 2'd0;
    localparam logic [1:0] REG_PRUNE_MODE   = 2'd1;
    localparam logic [1:0] REG_FIRST_LOCAL  = 2'd2;
    localparam logic [1:0] REG_LOCAL_COUNT  = 2'd3;

    // One request on the box channel
    typedef struct packed {
        logic                       operation;
        logic [SLOT_W-1:0]          slot;
        logic signed [FIELD_W-1:0]  lo_x;
        logic signed [FIELD_W-1:0]  lo_y;
        logic signed [FIELD_W-1:0]  lo_z;
        logic signed [FIELD_W-1:0]  hi_x;
        logic signed [FIELD_W-1:0]  hi_y;
        logic signed [FIELD_W-1:0]  hi_z;
        logic [PERIOD_W-1:0]        period_number;
    } box_req_t;

    // One result
    typedef struct packed {
        logic                       kind;
        logic [SLOT_W-1:0]          local_slot;
        logic [RANK_OUT_W-1:0]      neighbor_rank;
        logic [PERIOD_W-1:0]        neighbor_period;
        logic                       kept;
        logic                       last;
    } result_t;

endpackage

### sv/bnf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bnf_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/box_neighbor_filter_top.sv
// Box neighbour filter: local box store, slot sweep sequencer and result register.
// Load request: stored when slot < MAX_LOCAL, no result; the next request may follow at once.
// Candidate request, n = min(local_count, MAX_LOCAL) slots: one slot per cycle through the
//   gap unit while the result side does not stall, then a summary result closes the request;
//   the next request is accepted once the sequencer is back in idle.
// Reset clears control and configuration registers and counters at once; the box RAM needs no clearing pass.
module box_neighbor_filter_top #(
    parameter int MAX_LOCAL  = 16,
    parameter int COORD_BITS = 32,
    parameter int RANK_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // box request channel
    input  logic                              box_valid,
    output logic                              box_stall,
    input  bnf_pkg::box_req_t                 box_data,
    // result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output bnf_pkg::result_t                  res_data,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bnf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bnf_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bnf_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int IDX_W  = (MAX_LOCAL > 1) ? $clog2(MAX_LOCAL) : 1;
    localparam int CNT_W  = $clog2(MAX_LOCAL + 1);
    localparam int CMP_W  = (COORD_BITS + 1 > bnf_pkg::DIST_W + 1) ?
                            COORD_BITS + 1 : bnf_pkg::DIST_W + 1;
    localparam int RAM_W  = 6 * COORD_BITS;
    localparam int SUM_W  = bnf_pkg::SEQ_W + 1;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SWEEP   = 2'd1;
    localparam logic [1:0] S_SUMMARY = 2'd2;

    // configuration registers
    logic [bnf_pkg::DIST_W-1:0]   max_dist_reg;
    logic                         prune_reg;
    logic [bnf_pkg::SEQ_W-1:0]    first_reg;
    logic [bnf_pkg::LCOUNT_W-1:0] lcount_reg;

    // control state
    logic [1:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             issue_reg, issue_next;
    logic                         keep_reg, keep_next;
    logic [bnf_pkg::SEQ_W-1:0]    seq_reg, seq_next;
    logic [RANK_BITS-1:0]         rank_reg, rank_next;
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s2_valid_reg, s2_valid_next;
    logic                         out_valid_reg, out_valid_next;

    // payload state
    logic [COORD_BITS-1:0]        cand_lo_reg [3];
    logic [COORD_BITS-1:0]        cand_hi_reg [3];
    logic [bnf_pkg::PERIOD_W-1:0] period_reg;
    logic                         s1_self_reg;
    logic [IDX_W-1:0]             s1_slot_reg;
    logic                         s2_self_reg;
    logic [IDX_W-1:0]             s2_slot_reg;
    logic signed [CMP_W-1:0]      s2_diff_reg [6];
    logic signed [CMP_W-1:0]      s2_diff_next [6];
    bnf_pkg::result_t             out_reg, out_next;

    logic                         box_accept;
    logic                         cfg_write;
    logic                         adv;
    logic                         issuing;
    logic                         hit;
    logic                         self_now;
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [RAM_W-1:0]             ram_wdata;
    logic [RAM_W-1:0]             ram_rdata;

    assign box_accept = box_valid && !box_stall;
    assign box_stall  = (state_reg != S_IDLE);
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign adv        = !out_valid_reg || !res_stall;
    assign issuing    = (state_reg == S_SWEEP) && (issue_reg < count_reg) && adv;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= '0;
            prune_reg    <= 1'b0;
            first_reg    <= '0;
            lcount_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                bnf_pkg::REG_GAP_LIMIT:    max_dist_reg <= pwdata[bnf_pkg::DIST_W-1:0];
                bnf_pkg::REG_PRUNE_MODE:   prune_reg    <= pwdata[0];
                bnf_pkg::REG_FIRST_LOCAL:  first_reg    <= pwdata[bnf_pkg::SEQ_W-1:0];
                bnf_pkg::REG_LOCAL_COUNT:  lcount_reg   <= pwdata[bnf_pkg::LCOUNT_W-1:0];
                default:                   lcount_reg   <= lcount_reg;
            endcase
        end
    end

    // configuration reads
    always_comb
    begin
        unique case (paddr[3:2])
            bnf_pkg::REG_GAP_LIMIT:    prdata = bnf_pkg::CFG_DATA_W'(max_dist_reg);
            bnf_pkg::REG_PRUNE_MODE:   prdata = bnf_pkg::CFG_DATA_W'(prune_reg);
            bnf_pkg::REG_FIRST_LOCAL:  prdata = bnf_pkg::CFG_DATA_W'(first_reg);
            bnf_pkg::REG_LOCAL_COUNT:  prdata = bnf_pkg::CFG_DATA_W'(lcount_reg);
            default:                   prdata = '0;
        endcase
    end

    // local box store: {hi_z, hi_y, hi_x, lo_z, lo_y, lo_x}
    assign ram_we    = box_accept && (box_data.operation == bnf_pkg::OP_LOAD) &&
                       (32'(box_data.slot) < MAX_LOCAL);
    assign ram_waddr = IDX_W'(box_data.slot);
    assign ram_wdata = {box_data.hi_z[COORD_BITS-1:0], box_data.hi_y[COORD_BITS-1:0],
                        box_data.hi_x[COORD_BITS-1:0], box_data.lo_z[COORD_BITS-1:0],
                        box_data.lo_y[COORD_BITS-1:0], box_data.lo_x[COORD_BITS-1:0]};

    bnf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_LOCAL)
    ) u_local_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issuing),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // gap unit: six signed differences, each must stay at or below the gap limit
    always_comb
    begin
        logic signed [CMP_W-1:0] c_lo, c_hi, l_lo, l_hi;
        for (int d = 0; d < 3; d++)
        begin
            c_lo = CMP_W'($signed(cand_lo_reg[d]));
            c_hi = CMP_W'($signed(cand_hi_reg[d]));
            l_lo = CMP_W'($signed(ram_rdata[d*COORD_BITS +: COORD_BITS]));
            l_hi = CMP_W'($signed(ram_rdata[(d+3)*COORD_BITS +: COORD_BITS]));
            s2_diff_next[2*d]   = c_lo - l_hi;
            s2_diff_next[2*d+1] = l_lo - c_hi;
        end
    end

    always_comb
    begin
        logic in_range;
        in_range = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            if (s2_diff_reg[i] > $signed(CMP_W'(max_dist_reg)))
            begin
                in_range = 1'b0;
            end
        end
        hit = s2_valid_reg && !s2_self_reg && in_range;
    end

    // slot that is the candidate itself
    assign self_now = ({1'b0, seq_reg} == (SUM_W'(first_reg) + SUM_W'(issue_reg)));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        keep_next      = keep_reg;
        seq_next       = seq_reg;
        rank_next      = rank_reg;
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = adv ? 1'b0 : out_valid_reg;
        out_next       = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (box_accept)
                begin
                    if (box_data.operation == bnf_pkg::OP_LOAD)
                    begin
                        seq_next  = '0;
                        rank_next = '0;
                    end
                    else
                    begin
                        if (32'(lcount_reg) > MAX_LOCAL)
                        begin
                            count_next = CNT_W'(MAX_LOCAL);
                        end
                        else
                        begin
                            count_next = CNT_W'(lcount_reg);
                        end
                        issue_next    = '0;
                        keep_next     = 1'b0;
                        s1_valid_next = 1'b0;
                        s2_valid_next = 1'b0;
                        state_next    = S_SWEEP;
                    end
                end
            end
            S_SWEEP:
            begin
                if (adv)
                begin
                    s1_valid_next = issuing;
                    s2_valid_next = s1_valid_reg;
                    if (issuing)
                    begin
                        issue_next = issue_reg + 1'b1;
                    end
                    keep_next = keep_reg | (s2_valid_reg & (s2_self_reg | hit));
                    if (hit)
                    begin
                        out_valid_next           = 1'b1;
                        out_next.kind            = bnf_pkg::KIND_MATCH;
                        out_next.local_slot      = bnf_pkg::SLOT_W'(s2_slot_reg);
                        out_next.neighbor_rank   = bnf_pkg::RANK_OUT_W'(rank_reg);
                        out_next.neighbor_period = period_reg;
                        out_next.kept            = 1'b1;
                        out_next.last            = 1'b0;
                    end
                end
                if ((issue_reg == count_reg) && !s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = S_SUMMARY;
                end
            end
            S_SUMMARY:
            begin
                if (adv)
                begin
                    out_valid_next           = 1'b1;
                    out_next.kind            = bnf_pkg::KIND_SUMMARY;
                    out_next.local_slot      = '0;
                    out_next.neighbor_rank   = bnf_pkg::RANK_OUT_W'(rank_reg);
                    out_next.neighbor_period = period_reg;
                    out_next.kept            = keep_reg;
                    out_next.last            = 1'b1;
                    if ((!prune_reg || keep_reg) && (rank_reg != '1))
                    begin
                        rank_next = rank_reg + 1'b1;
                    end
                    seq_next   = seq_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            keep_reg      <= 1'b0;
            seq_reg       <= '0;
            rank_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            keep_reg      <= keep_next;
            seq_reg       <= seq_next;
            rank_reg      <= rank_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (box_accept && (box_data.operation == bnf_pkg::OP_CAND))
        begin
            cand_lo_reg[0] <= box_data.lo_x[COORD_BITS-1:0];
            cand_lo_reg[1] <= box_data.lo_y[COORD_BITS-1:0];
            cand_lo_reg[2] <= box_data.lo_z[COORD_BITS-1:0];
            cand_hi_reg[0] <= box_data.hi_x[COORD_BITS-1:0];
            cand_hi_reg[1] <= box_data.hi_y[COORD_BITS-1:0];
            cand_hi_reg[2] <= box_data.hi_z[COORD_BITS-1:0];
            period_reg     <= box_data.period_number;
        end
        if ((state_reg == S_SWEEP) && adv)
        begin
            s1_self_reg <= self_now;
            s1_slot_reg <= issue_reg[IDX_W-1:0];
            s2_self_reg <= s1_self_reg;
            s2_slot_reg <= s1_slot_reg;
            s2_diff_reg <= s2_diff_next;
        end
    end

    // checks
    a_cand_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        box_accept && (box_data.operation == bnf_pkg::OP_CAND) |=> (state_reg == S_SWEEP))
        else $error("candidate did not start a slot sweep");

    a_summary_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUMMARY) && adv |=> res_valid && res_data.last)
        else $error("summary state did not issue the closing result");

    a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (issue_reg <= count_reg))
        else $error("slot issue ran past the local count");

    a_load_clears_rank: assert property (@(posedge clk) disable iff (!rst_n)
        box_accept && (box_data.operation == bnf_pkg::OP_LOAD) |=>
        (rank_reg == '0) && (seq_reg == '0))
        else $error("load did not clear the pass counters");

endmodule
